[sv/sbwa_pkg.sv]
// ----------------------------------------------------------------------------
// sbwa_pkg
// shared types and constants of the spectrum bin window averager
// ----------------------------------------------------------------------------
package sbwa_pkg;

  localparam int BIN_DEPTH = 4096;
  localparam int BIN_AW    = $clog2(BIN_DEPTH);

  localparam int SUM_W     = 32;
  localparam int CNT_W     = 16;
  localparam int ENTRY_W   = SUM_W + CNT_W;
  localparam int POS_W     = 13;
  localparam int PIX_W     = 12;
  localparam int WIN_W     = 6;
  localparam int TOT_W     = 13;
  localparam int NUM_W     = 6;

  // dividend wide enough for the sum of up to 63 signed 32-bit means
  localparam int DVD_W     = 38;
  localparam int DIV_CW    = $clog2(DVD_W);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_TOTAL  = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1);
  localparam logic [TOT_W-1:0] TOTAL_RESET  = TOT_W'(4096);

  typedef struct packed {
    logic                    start;
    logic signed [DVD_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/sbwa_ram.sv]
// ----------------------------------------------------------------------------
// sbwa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sbwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/sbwa_div.sv]
// ----------------------------------------------------------------------------
// sbwa_div
// iterative signed by unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero
// ----------------------------------------------------------------------------
module sbwa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbwa_pkg::div_req_t  req_i,
  output sbwa_pkg::div_rsp_t  rsp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [sbwa_pkg::DIV_CW-1:0]       cnt_q, cnt_d;
  logic                              neg_q, neg_d;
  logic [sbwa_pkg::DVD_W-1:0]        quo_q, quo_d;
  logic [sbwa_pkg::CNT_W-1:0]        rem_q, rem_d;
  logic [sbwa_pkg::CNT_W-1:0]        dvs_q, dvs_d;
  logic [sbwa_pkg::CNT_W:0]          shifted;
  logic [sbwa_pkg::CNT_W:0]          diff;
  logic                              fits;

  assign shifted = {rem_q, quo_q[sbwa_pkg::DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = sbwa_pkg::DIV_CW'(sbwa_pkg::DVD_W - 1);
      neg_d  = req_i.dividend[sbwa_pkg::DVD_W-1];
      quo_d  = req_i.dividend[sbwa_pkg::DVD_W-1] ? -req_i.dividend : req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[sbwa_pkg::CNT_W-1:0] : shifted[sbwa_pkg::CNT_W-1:0];
      quo_d = {quo_q[sbwa_pkg::DVD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -signed'(quo_q) : signed'(quo_q);

endmodule

[sv/spectrum_bin_window_average.sv]
// ----------------------------------------------------------------------------
// spectrum_bin_window_average
// table of spectrum bins with a centered window average of the bin means
// ----------------------------------------------------------------------------
// input stream: tuser holds op, a write transaction stores one bin's sum and
// count, a query transaction returns one result on the output stream
// output stream: tuser is the found flag, tdata the average in Q23.8 dB
// apb port: window_size at byte address 0, bin total at byte address 4
// after reset the bin table is cleared one entry per cycle while the
// input is not ready; configuration writes are taken
// a write is stored as it is accepted; a query walks the window one bin
// at a time, ST_READ then ST_CHECK for each bin; a non-empty bin's mean
// then goes through the shared divider in ST_DIVB, and the final average
// through it in ST_DIVF before ST_FINISH; a window spans up to 63 bins
// one query is worked on at a time and the input is not ready meanwhile
// the result waits in an output register; while it is held, a finished
// query waits in ST_FINISH with input not ready, else writes keep flowing
// ----------------------------------------------------------------------------
module spectrum_bin_window_average (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // pixel, bin_sum, bin_count, zero pad
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // average_db
  output logic        m_axis_tuser,   // found
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_DIVB   = 3'd4;
  localparam logic [2:0] ST_DIVF   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0]                            state_q, state_d;
  logic [sbwa_pkg::WIN_W-1:0]            window_q;
  logic [sbwa_pkg::TOT_W-1:0]            total_q;
  logic [sbwa_pkg::BIN_AW-1:0]           clr_q, clr_d;
  logic [sbwa_pkg::POS_W-1:0]            pos_q, pos_d;
  logic [sbwa_pkg::POS_W-1:0]            end_q, end_d;
  logic signed [sbwa_pkg::DVD_W-1:0]     acc_q, acc_d;
  logic [sbwa_pkg::NUM_W-1:0]            num_q, num_d;
  logic                                  res_found_q, res_found_d;
  logic [31:0]                           res_avg_q, res_avg_d;
  logic                                  out_valid_q, out_valid_d;
  logic                                  out_found_q, out_found_d;
  logic [31:0]                           out_avg_q, out_avg_d;

  logic [sbwa_pkg::PIX_W-1:0]            in_pixel;
  logic [sbwa_pkg::SUM_W-1:0]            in_sum;
  logic [sbwa_pkg::CNT_W-1:0]            in_count;
  logic                                  in_accept;
  logic                                  cfg_write;
  logic [sbwa_pkg::POS_W-1:0]            pix_pos;
  logic [sbwa_pkg::POS_W-1:0]            half;
  logic [sbwa_pkg::POS_W-1:0]            win_start;
  logic [sbwa_pkg::POS_W-1:0]            win_end;
  logic [sbwa_pkg::POS_W-1:0]            reach;
  logic [sbwa_pkg::POS_W-1:0]            limit;

  logic                                  ram_we;
  logic [sbwa_pkg::BIN_AW-1:0]           ram_waddr;
  logic [sbwa_pkg::ENTRY_W-1:0]          ram_wdata;
  logic [sbwa_pkg::ENTRY_W-1:0]          ram_rdata;
  logic [sbwa_pkg::CNT_W-1:0]            rd_count;
  logic [sbwa_pkg::SUM_W-1:0]            rd_sum;

  sbwa_pkg::div_req_t                    div_req;
  sbwa_pkg::div_rsp_t                    div_rsp;

  // input unpacking
  assign in_pixel  = s_axis_tdata[11:0];
  assign in_sum    = s_axis_tdata[43:12];
  assign in_count  = s_axis_tdata[59:44];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= sbwa_pkg::WINDOW_RESET;
      total_q  <= sbwa_pkg::TOTAL_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        sbwa_pkg::REG_WINDOW: window_q <= pwdata[sbwa_pkg::WIN_W-1:0];
        sbwa_pkg::REG_TOTAL:  total_q  <= pwdata[sbwa_pkg::TOT_W-1:0];
        default:              window_q <= window_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sbwa_pkg::REG_WINDOW: prdata = 32'(window_q);
      sbwa_pkg::REG_TOTAL:  prdata = 32'(total_q);
      default:              prdata = '0;
    endcase
  end

  // window bounds
  assign pix_pos = sbwa_pkg::POS_W'(in_pixel);
  assign half    = sbwa_pkg::POS_W'(window_q >> 1);
  assign reach   = pix_pos + half;
  assign limit   = total_q - 1'b1;

  always_comb begin
    if (window_q <= sbwa_pkg::WIN_W'(1)) begin
      win_start = pix_pos;
      win_end   = pix_pos;
    end else begin
      win_start = (pix_pos > half) ? (pix_pos - half) : '0;
      win_end   = (reach > limit) ? limit : reach;
    end
  end

  // bin table
  assign ram_we    = (state_q == ST_CLEAR) ||
                     (in_accept && s_axis_tuser == sbwa_pkg::OP_WRITE &&
                      32'(in_pixel) < 32'(sbwa_pkg::BIN_DEPTH));
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : sbwa_pkg::BIN_AW'(in_pixel);
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : {in_count, in_sum};
  assign rd_count  = ram_rdata[sbwa_pkg::ENTRY_W-1:sbwa_pkg::SUM_W];
  assign rd_sum    = ram_rdata[sbwa_pkg::SUM_W-1:0];

  sbwa_ram #(
    .WIDTH (sbwa_pkg::ENTRY_W),
    .DEPTH (sbwa_pkg::BIN_DEPTH)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (sbwa_pkg::BIN_AW'(pos_q)),
    .rdata_o (ram_rdata)
  );

  sbwa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    end_d       = end_q;
    acc_d       = acc_q;
    num_d       = num_q;
    res_found_d = res_found_q;
    res_avg_d   = res_avg_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_found_d = out_found_q;
    out_avg_d   = out_avg_q;
    div_req.start    = 1'b0;
    div_req.dividend = sbwa_pkg::DVD_W'(signed'(rd_sum));
    div_req.divisor  = rd_count;

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == sbwa_pkg::BIN_AW'(sbwa_pkg::BIN_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept && s_axis_tuser == sbwa_pkg::OP_QUERY) begin
          pos_d   = win_start;
          end_d   = win_end;
          acc_d   = '0;
          num_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (pos_q > end_q || 32'(pos_q) >= 32'(sbwa_pkg::BIN_DEPTH)) begin
          if (num_q == '0) begin
            res_found_d = 1'b0;
            res_avg_d   = '0;
            state_d     = ST_FINISH;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = acc_q;
            div_req.divisor  = sbwa_pkg::CNT_W'(num_q);
            state_d          = ST_DIVF;
          end
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rd_count == '0) begin
          pos_d   = pos_q + 1'b1;
          state_d = ST_READ;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIVB;
        end
      end
      ST_DIVB: begin
        if (div_rsp.done) begin
          acc_d   = acc_q + div_rsp.quotient;
          num_d   = num_q + 1'b1;
          pos_d   = pos_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_DIVF: begin
        if (div_rsp.done) begin
          res_found_d = 1'b1;
          res_avg_d   = div_rsp.quotient[31:0];
          state_d     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_avg_d   = res_avg_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    end_q       <= end_d;
    acc_q       <= acc_d;
    num_q       <= num_d;
    res_found_q <= res_found_d;
    res_avg_q   <= res_avg_d;
    out_found_q <= out_found_d;
    out_avg_q   <= out_avg_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = out_avg_q;

  // checks
  a_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIVB || state_q == ST_DIVF))
    else $error("divider finished outside a division state");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_FINISH)
    else $error("result raised without a finished query");

  a_table_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR ||
                (state_q == ST_IDLE && s_axis_tuser == sbwa_pkg::OP_WRITE)))
    else $error("bin table written outside clearing or a write transaction");

  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_CHECK || state_q == ST_DIVB) |-> !s_axis_tready)
    else $error("input ready during a query");

endmodule
